// ----- hdl/eyews_pkg.sv -----
`timescale 1ns / 1ps
package eyews_pkg;

  // Q16 fraction width, one bit more than 16 so that 1.0 fits
  localparam int unsigned Q_W = 17;
  localparam logic [Q_W-1:0] Q16_ONE = 17'h10000;

  typedef logic [Q_W-1:0] q17_t;

  // configuration register indexes
  localparam logic [2:0] REG_ROLLING_WINDOW  = 3'd0;
  localparam logic [2:0] REG_MAX_SAMPLE_GAP  = 3'd1;
  localparam logic [2:0] REG_MIN_KNOWN_COV   = 3'd2;
  localparam logic [2:0] REG_CUMULATIVE_EN   = 3'd3;
  localparam logic [2:0] REG_ROLLING_EN      = 3'd4;

  // eye state codes
  localparam logic [1:0] EYE_UNKNOWN = 2'd0;
  localparam logic [1:0] EYE_OPEN    = 2'd1;

  // operand select of the shared ratio unit
  localparam logic [1:0] DIV_CUM_COV  = 2'd0;
  localparam logic [1:0] DIV_CUM_OPEN = 2'd1;
  localparam logic [1:0] DIV_ROL_COV  = 2'd2;
  localparam logic [1:0] DIV_ROL_OPEN = 2'd3;

endpackage

// ----- hdl/eyews_ram.sv -----
`timescale 1ns / 1ps
module eyews_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/eyews_ratio.sv -----
`timescale 1ns / 1ps
module eyews_ratio #(
  parameter int unsigned TW = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [TW-1:0]   num,
  input  logic [TW-1:0]   den,
  output logic            done,
  output eyews_pkg::q17_t q
);
  import eyews_pkg::*;

  logic          busy_r;
  logic          done_r;
  logic [3:0]    cnt_r;
  logic [TW-1:0] rem_r;
  logic [TW-1:0] den_r;
  q17_t          q_r;
  logic [TW:0]   rem_sh;
  logic [TW:0]   rem_sub;
  logic          take;

  // one restoring step per cycle
  assign rem_sh  = {rem_r, 1'b0};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign take    = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= num;
        den_r <= den;
        cnt_r <= 4'd15;
        q_r   <= '0;
        // settle the trivial cases at once
        if (den == '0) begin
          done_r <= 1'b1;
        end else if (num >= den) begin
          q_r    <= Q16_ONE;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= take ? rem_sub[TW-1:0] : rem_sh[TW-1:0];
        q_r   <= {q_r[Q_W-2:0], take};
        cnt_r <= cnt_r - 4'd1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

// ----- hdl/eye_state_window_statistics.sv -----
`timescale 1ns / 1ps
// Eye state window statistics. Each sample with a later timestamp than the
// last closes the interval since the previous sample, keeps it in an
// interval ring memory and blink times in a blink ring memory, drops entries
// older than the rolling window and returns one result with cumulative and
// rolling coverage, Q16 open ratios and blink counts. Rolling known and open
// time are kept as running sums, so the rings are only touched at their
// ends. The four Q16 ratios go one after another through one shared radix-2
// ratio unit. A trimmed entry costs a memory read and a check; a dropped
// interval costs the same plus a second pass through the push state. A new
// sample is taken once the previous one has been handed to the output
// register. Both rings start empty after reset; no clearing pass.
module eye_state_window_statistics #(
  parameter int unsigned INTERVAL_DEPTH = 256,
  parameter int unsigned BLINK_DEPTH    = 256,
  parameter int unsigned TIME_WIDTH     = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TIME_WIDTH-1:0] in_timestamp,
  input  logic [1:0]            in_eye_state,
  input  logic                  in_blink,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_update_accepted,
  output logic [16:0]           out_cumulative_known_coverage,
  output logic [16:0]           out_cumulative_eye_open,
  output logic                  out_cumulative_open_valid,
  output logic [31:0]           out_cumulative_blink_count,
  output logic [16:0]           out_rolling_known_coverage,
  output logic [16:0]           out_rolling_eye_open,
  output logic                  out_rolling_open_valid,
  output logic [8:0]            out_rolling_blink_count,
  output logic                  out_store_overflow,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data
);
  import eyews_pkg::*;

  localparam int unsigned TW  = TIME_WIDTH;
  localparam int unsigned CW  = (TW > 32) ? TW : 32;
  localparam int unsigned IW  = $clog2(INTERVAL_DEPTH);
  localparam int unsigned ICW = $clog2(INTERVAL_DEPTH + 1);
  localparam int unsigned BW  = $clog2(BLINK_DEPTH);
  localparam int unsigned BCW = $clog2(BLINK_DEPTH + 1);
  localparam int unsigned EW  = 2 * TW + 2;

  typedef enum logic [11:0] {
    S_IDLE      = 12'b000000000001,
    S_PUSH      = 12'b000000000010,
    S_IOVF_RD   = 12'b000000000100,
    S_IOVF_CHK  = 12'b000000001000,
    S_BLINK     = 12'b000000010000,
    S_TRIM_RD   = 12'b000000100000,
    S_TRIM_CHK  = 12'b000001000000,
    S_BTRIM_RD  = 12'b000010000000,
    S_BTRIM_CHK = 12'b000100000000,
    S_DIV_GO    = 12'b001000000000,
    S_DIV_WAIT  = 12'b010000000000,
    S_DONE      = 12'b100000000000
  } fsm_t;

  fsm_t state_r;

  // configuration
  logic [31:0] window_r;
  logic [31:0] max_gap_r;
  q17_t        min_cov_r;
  logic        cum_en_r;
  logic        roll_en_r;

  // sample state
  logic          started_r;
  logic          first_item_r;
  logic          accepted_r;
  logic          blink_r;
  logic [TW-1:0] first_time_r;
  logic [TW-1:0] prev_time_r;
  logic [1:0]    prev_state_r;
  logic [TW-1:0] now_r;
  logic [TW-1:0] push_start_r;
  logic [1:0]    push_tag_r;
  logic [TW-1:0] known_r;
  logic [TW-1:0] open_r;
  logic [TW-1:0] rk_r;
  logic [TW-1:0] ro_r;
  logic [31:0]   blinks_r;
  logic          ovf_r;

  // ring pointers
  logic [IW-1:0]  ihead_r;
  logic [ICW-1:0] icnt_r;
  logic [BW-1:0]  bhead_r;
  logic [BCW-1:0] bcnt_r;

  // ratio results
  logic [1:0] sel_r;
  q17_t       ccov_r;
  q17_t       copen_r;
  q17_t       rcov_r;
  q17_t       ropen_r;

  // output register
  logic        out_valid_r;
  logic        o_acc_r;
  q17_t        o_ccov_r;
  q17_t        o_copen_r;
  logic        o_cvalid_r;
  logic [31:0] o_cblinks_r;
  q17_t        o_rcov_r;
  q17_t        o_ropen_r;
  logic        o_rvalid_r;
  logic [8:0]  o_rblinks_r;
  logic        o_ovf_r;

  // memory ports
  logic          iwe;
  logic [IW-1:0] iwaddr;
  logic [EW-1:0] iwdata;
  logic [EW-1:0] irdata;
  logic          bwe;
  logic [BW-1:0] bwaddr;
  logic [TW-1:0] brdata;

  // combinational helpers
  logic [TW-1:0]  dur;
  logic [1:0]     tag;
  logic [IW:0]    isum_w;
  logic [IW-1:0]  itail;
  logic [IW-1:0]  ihead_inc;
  logic [BW:0]    bsum_w;
  logic [BW-1:0]  btail;
  logic [BW-1:0]  bhead_inc;
  logic           ifull;
  logic           bfull;
  logic           trim_en;
  logic [CW-1:0]  ws_w;
  logic [TW-1:0]  ws;
  logic [TW-1:0]  ent_start;
  logic [TW-1:0]  ent_end;
  logic [1:0]     ent_tag;
  logic [TW-1:0]  ent_len;
  logic [TW-1:0]  clip_len;
  logic [TW-1:0]  elapsed;
  logic [TW-1:0]  avail;
  logic [TW-1:0]  div_num;
  logic [TW-1:0]  div_den;
  logic           div_start;
  logic           div_done;
  q17_t           div_q;
  logic           cvalid;
  logic           rvalid;
  logic [BCW+8:0] bcnt_ext;

  // interval ring entry: state, start, end
  eyews_ram #(.WIDTH(EW), .DEPTH(INTERVAL_DEPTH)) u_iram (
    .clk(clk), .we(iwe), .waddr(iwaddr), .wdata(iwdata),
    .raddr(ihead_r), .rdata(irdata)
  );

  eyews_ram #(.WIDTH(TW), .DEPTH(BLINK_DEPTH)) u_bram (
    .clk(clk), .we(bwe), .waddr(bwaddr), .wdata(now_r),
    .raddr(bhead_r), .rdata(brdata)
  );

  eyews_ratio #(.TW(TW)) u_ratio (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(div_num), .den(div_den), .done(div_done), .q(div_q)
  );

  // ring slot arithmetic
  always_comb begin
    isum_w = {1'b0, ihead_r} + (IW+1)'(icnt_r);
    if (isum_w >= (IW+1)'(INTERVAL_DEPTH)) begin
      isum_w = isum_w - (IW+1)'(INTERVAL_DEPTH);
    end
    itail = isum_w[IW-1:0];
    bsum_w = {1'b0, bhead_r} + (BW+1)'(bcnt_r);
    if (bsum_w >= (BW+1)'(BLINK_DEPTH)) begin
      bsum_w = bsum_w - (BW+1)'(BLINK_DEPTH);
    end
    btail = bsum_w[BW-1:0];
  end

  assign ihead_inc = (ihead_r == IW'(INTERVAL_DEPTH - 1)) ? '0 : ihead_r + IW'(1);
  assign bhead_inc = (bhead_r == BW'(BLINK_DEPTH - 1)) ? '0 : bhead_r + BW'(1);
  assign ifull     = (icnt_r == ICW'(INTERVAL_DEPTH));
  assign bfull     = (bcnt_r == BCW'(BLINK_DEPTH));

  // interval close and window start
  assign dur     = in_timestamp - prev_time_r;
  assign tag     = (CW'(dur) <= CW'(max_gap_r)) ? prev_state_r : EYE_UNKNOWN;
  assign trim_en = (CW'(now_r) >= CW'(window_r));
  assign ws_w    = CW'(now_r) - CW'(window_r);
  assign ws      = ws_w[TW-1:0];

  assign ent_tag   = irdata[EW-1 -: 2];
  assign ent_start = irdata[2*TW-1 -: TW];
  assign ent_end   = irdata[TW-1:0];
  assign ent_len   = ent_end - ent_start;
  assign clip_len  = ws - ent_start;

  assign elapsed = now_r - first_time_r;
  assign avail   = (CW'(window_r) < CW'(elapsed)) ? window_r[TW-1:0] : elapsed;

  // memory writes
  always_comb begin
    iwe    = 1'b0;
    iwaddr = itail;
    iwdata = {push_tag_r, push_start_r, now_r};
    bwe    = 1'b0;
    bwaddr = bfull ? bhead_r : btail;
    if (state_r == S_PUSH && !ifull) begin
      iwe = 1'b1;
    end
    if (state_r == S_TRIM_CHK && icnt_r != '0 && !(ent_end <= ws) && ent_start < ws) begin
      iwe    = 1'b1;
      iwaddr = ihead_r;
      iwdata = {ent_tag, ws, ent_end};
    end
    if (state_r == S_BLINK && blink_r) begin
      bwe = 1'b1;
    end
  end

  // ratio operand select
  always_comb begin
    unique case (sel_r)
      DIV_CUM_COV: begin
        div_num = known_r;
        div_den = elapsed;
      end
      DIV_CUM_OPEN: begin
        div_num = open_r;
        div_den = known_r;
      end
      DIV_ROL_COV: begin
        div_num = rk_r;
        div_den = avail;
      end
      default: begin
        div_num = ro_r;
        div_den = rk_r;
      end
    endcase
  end
  assign div_start = (state_r == S_DIV_GO);

  assign cvalid   = cum_en_r && (known_r != '0);
  assign rvalid   = roll_en_r && (rk_r != '0) && (rcov_r >= min_cov_r);
  assign bcnt_ext = {9'b0, bcnt_r};

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= 32'd30000;
      max_gap_r <= 32'd500;
      min_cov_r <= '0;
      cum_en_r  <= 1'b1;
      roll_en_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROLLING_WINDOW: window_r  <= cfg_data;
        REG_MAX_SAMPLE_GAP: max_gap_r <= cfg_data;
        REG_MIN_KNOWN_COV:  min_cov_r <= cfg_data[Q_W-1:0];
        REG_CUMULATIVE_EN:  cum_en_r  <= cfg_data[0];
        REG_ROLLING_EN:     roll_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      started_r    <= 1'b0;
      first_item_r <= 1'b0;
      accepted_r   <= 1'b0;
      blink_r      <= 1'b0;
      first_time_r <= '0;
      prev_time_r  <= '0;
      prev_state_r <= EYE_UNKNOWN;
      now_r        <= '0;
      known_r      <= '0;
      open_r       <= '0;
      rk_r         <= '0;
      ro_r         <= '0;
      blinks_r     <= '0;
      ovf_r        <= 1'b0;
      ihead_r      <= '0;
      icnt_r       <= '0;
      bhead_r      <= '0;
      bcnt_r       <= '0;
      sel_r        <= DIV_CUM_COV;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            blink_r <= in_blink;
            sel_r   <= DIV_CUM_COV;
            if (!started_r) begin
              started_r    <= 1'b1;
              first_item_r <= 1'b1;
              accepted_r   <= 1'b1;
              first_time_r <= in_timestamp;
              prev_time_r  <= in_timestamp;
              prev_state_r <= in_eye_state;
              now_r        <= in_timestamp;
              state_r      <= S_BLINK;
            end else if (in_timestamp <= prev_time_r) begin
              // hold state, report again at the last time
              accepted_r <= 1'b0;
              now_r      <= prev_time_r;
              state_r    <= S_DIV_GO;
            end else begin
              first_item_r <= 1'b0;
              accepted_r   <= 1'b1;
              push_start_r <= prev_time_r;
              push_tag_r   <= tag;
              if (tag != EYE_UNKNOWN) begin
                known_r <= known_r + dur;
                rk_r    <= rk_r + dur;
                if (tag == EYE_OPEN) begin
                  open_r <= open_r + dur;
                  ro_r   <= ro_r + dur;
                end
              end
              prev_time_r  <= in_timestamp;
              prev_state_r <= in_eye_state;
              now_r        <= in_timestamp;
              state_r      <= S_PUSH;
            end
          end
        end
        S_PUSH: begin
          if (ifull) begin
            state_r <= S_IOVF_RD;
          end else begin
            icnt_r  <= icnt_r + ICW'(1);
            state_r <= S_BLINK;
          end
        end
        S_IOVF_RD: state_r <= S_IOVF_CHK;
        S_IOVF_CHK: begin
          // drop the oldest interval to make room
          if (ent_tag != EYE_UNKNOWN) begin
            rk_r <= rk_r - ent_len;
            if (ent_tag == EYE_OPEN) begin
              ro_r <= ro_r - ent_len;
            end
          end
          ihead_r <= ihead_inc;
          icnt_r  <= icnt_r - ICW'(1);
          ovf_r   <= 1'b1;
          state_r <= S_PUSH;
        end
        S_BLINK: begin
          if (blink_r) begin
            blinks_r <= blinks_r + 32'd1;
            if (bfull) begin
              bhead_r <= bhead_inc;
              ovf_r   <= 1'b1;
            end else begin
              bcnt_r <= bcnt_r + BCW'(1);
            end
          end
          state_r <= (!first_item_r && trim_en) ? S_TRIM_RD : S_DIV_GO;
        end
        S_TRIM_RD: state_r <= (icnt_r == '0) ? S_BTRIM_RD : S_TRIM_CHK;
        S_TRIM_CHK: begin
          if (ent_end <= ws) begin
            // interval wholly before the window
            if (ent_tag != EYE_UNKNOWN) begin
              rk_r <= rk_r - ent_len;
              if (ent_tag == EYE_OPEN) begin
                ro_r <= ro_r - ent_len;
              end
            end
            ihead_r <= ihead_inc;
            icnt_r  <= icnt_r - ICW'(1);
            state_r <= S_TRIM_RD;
          end else begin
            // clip the oldest interval to the window start
            if (ent_start < ws && ent_tag != EYE_UNKNOWN) begin
              rk_r <= rk_r - clip_len;
              if (ent_tag == EYE_OPEN) begin
                ro_r <= ro_r - clip_len;
              end
            end
            state_r <= S_BTRIM_RD;
          end
        end
        S_BTRIM_RD: state_r <= (bcnt_r == '0) ? S_DIV_GO : S_BTRIM_CHK;
        S_BTRIM_CHK: begin
          if (brdata < ws) begin
            bhead_r <= bhead_inc;
            bcnt_r  <= bcnt_r - BCW'(1);
            state_r <= S_BTRIM_RD;
          end else begin
            state_r <= S_DIV_GO;
          end
        end
        S_DIV_GO: state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            unique case (sel_r)
              DIV_CUM_COV:  ccov_r  <= div_q;
              DIV_CUM_OPEN: copen_r <= div_q;
              DIV_ROL_COV:  rcov_r  <= div_q;
              default:      ropen_r <= div_q;
            endcase
            if (sel_r == DIV_ROL_OPEN) begin
              state_r <= S_DONE;
            end else begin
              sel_r   <= sel_r + 2'd1;
              state_r <= S_DIV_GO;
            end
          end
        end
        S_DONE: begin
          // load the output register once it is free
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            o_acc_r     <= accepted_r;
            o_ccov_r    <= ccov_r;
            o_copen_r   <= cvalid ? copen_r : '0;
            o_cvalid_r  <= cvalid;
            o_cblinks_r <= cum_en_r ? blinks_r : '0;
            o_rcov_r    <= rcov_r;
            o_ropen_r   <= rvalid ? ropen_r : '0;
            o_rvalid_r  <= rvalid;
            o_rblinks_r <= roll_en_r ? bcnt_ext[8:0] : '0;
            o_ovf_r     <= ovf_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready                      = (state_r == S_IDLE);
  assign out_valid                     = out_valid_r;
  assign out_update_accepted           = o_acc_r;
  assign out_cumulative_known_coverage = o_ccov_r;
  assign out_cumulative_eye_open       = o_copen_r;
  assign out_cumulative_open_valid     = o_cvalid_r;
  assign out_cumulative_blink_count    = o_cblinks_r;
  assign out_rolling_known_coverage    = o_rcov_r;
  assign out_rolling_eye_open          = o_ropen_r;
  assign out_rolling_open_valid        = o_rvalid_r;
  assign out_rolling_blink_count       = o_rblinks_r;
  assign out_store_overflow            = o_ovf_r;

  a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (icnt_r <= ICW'(INTERVAL_DEPTH)) && (bcnt_r <= BCW'(BLINK_DEPTH)))
    else $error("ring count beyond depth");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r)
    else $error("overflow flag cleared");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("sequencer idle after transaction");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV_WAIT))
    else $error("ratio result outside wait state");

endmodule
